// ----- rtl/core/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants of the ordered list engine
// Request kinds, result status codes, the operation code broadcast to the
// storage cells and the controller state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

  // Default number of list entries.
  localparam int DEPTH_DEF = 128;

  // Field widths of the stream payloads.
  localparam int KIND_W   = 3;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 7;
  localparam int COUNT_W  = 8;

  // Request kinds carried in in_tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_UPDATE = 3'd3,
    KIND_SEARCH = 3'd4
  } req_kind_t;

  // Result status codes carried in out_tuser.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // Operation broadcast to every cell of the storage row.
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_DELETE = 3'd2,
    CELL_UPDATE = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_RESULT = 2'd2
  } ctrl_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/ole_cell.sv -----
// ----------------------------------------------------------------------------
// ole_cell: one storage cell of the ordered list row
// Holds one list entry and, on the broadcast operation, keeps it, loads the
// request value, or takes the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ole_cell #(
  parameter int IDX_W = 7,
  parameter int IDX   = 0
) (
  input  wire logic                                clk,
  input  wire ole_pkg::cell_op_t                   op,
  input  wire logic [IDX_W-1:0]                    pos,
  input  wire logic signed [ole_pkg::VALUE_W-1:0]  item_value,
  input  wire logic signed [ole_pkg::VALUE_W-1:0]  left_val,
  input  wire logic signed [ole_pkg::VALUE_W-1:0]  right_val,
  output      logic signed [ole_pkg::VALUE_W-1:0]  val_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [ole_pkg::VALUE_W-1:0] val_r;
  logic signed [ole_pkg::VALUE_W-1:0] val_nxt;

  // Select the next entry from the operation and this cell's place in the row.
  always_comb begin
    val_nxt = val_r;
    case (op)
      ole_pkg::CELL_INSERT: begin
        if (MY_IDX == pos) begin
          val_nxt = item_value;
        end else if (MY_IDX > pos) begin
          val_nxt = left_val;
        end
      end
      ole_pkg::CELL_DELETE: begin
        if (MY_IDX >= pos) begin
          val_nxt = right_val;
        end
      end
      ole_pkg::CELL_UPDATE: begin
        if (MY_IDX == pos) begin
          val_nxt = item_value;
        end
      end
      ole_pkg::CELL_ROTATE: begin
        val_nxt = right_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  // Entry storage; its contents are undefined until written.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;

endmodule

`default_nettype wire

// ----- rtl/core/ordered_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine: packed ordered list with insert, delete, read, update
// and search
// A row of DEPTH storage cells under one controller that takes requests from
// a stream input and returns one status transfer per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfer on the in_ channel carries the kind in in_tuser and the
//   position and value in in_tdata. Every request yields exactly one result
//   transfer on the out_ channel: status in out_tuser, read value, found index
//   and the entry count after the request in out_tdata.
//   Insert, delete, update and every rejected request are handled from the
//   idle state: all cells shift or load in parallel, and the result is in
//   the output register in the cycle after the transfer. Such requests can
//   be taken every cycle while the receiver keeps taking the results.
//   A valid read and a search with a non-empty list rotate the whole row once
//   through cell 0, one place per cycle, then load the output register once
//   it is free. The rotation length is set by the number of cells.
//   A new request is taken while the controller is idle and the output
//   register is empty or being emptied in the same cycle; a stalled receiver
//   therefore holds the result and blocks further requests.
//   Reset clears the entry count and the controller; the cells are not
//   cleared, since no entry at or above the count is ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [39:0] in_tdata,   // [7:0] position, [39:8] item_value
  input  wire logic [2:0]  in_tuser,   // [2:0] kind
  // Result channel.
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata,  // [31:0] read_value, [38:32] found_index,
                                       // [46:39] entry_count, [47] zero
  output      logic [1:0]  out_tuser   // [1:0] status
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W;

  localparam logic [CMP_W-1:0] DEPTH_C    = CMP_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(DEPTH);

  // Request fields.
  logic [ole_pkg::POS_W-1:0]          in_position;
  logic signed [ole_pkg::VALUE_W-1:0] in_item_value;
  logic                               in_fire;

  assign in_position   = in_tdata[7:0];
  assign in_item_value = in_tdata[39:8];

  // Controller registers.
  ole_pkg::ctrl_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]                   count_r, count_nxt;
  logic [IDX_W-1:0]                   scan_idx_r, scan_idx_nxt;
  logic                               is_search_r, is_search_nxt;
  logic signed [ole_pkg::VALUE_W-1:0] key_r, key_nxt;
  logic [CMP_W-1:0]                   pos_r, pos_nxt;
  logic                               hit_r, hit_nxt;
  logic signed [ole_pkg::VALUE_W-1:0] rd_r, rd_nxt;
  logic [IDX_W-1:0]                   found_r, found_nxt;

  // Output register.
  logic                               out_valid_r, out_valid_nxt;
  ole_pkg::status_t                   out_status_r, out_status_nxt;
  logic signed [ole_pkg::VALUE_W-1:0] out_read_r, out_read_nxt;
  logic [ole_pkg::FOUND_W-1:0]        out_found_r, out_found_nxt;
  logic [ole_pkg::COUNT_W-1:0]        out_count_r, out_count_nxt;

  // Cell row control.
  ole_pkg::cell_op_t                  cell_op;
  logic [IDX_W-1:0]                   cell_pos;
  logic signed [ole_pkg::VALUE_W-1:0] cell_val [DEPTH];

  logic out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ole_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Row of storage cells; the last cell wraps to cell 0 for the rotation.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic signed [ole_pkg::VALUE_W-1:0] left_v;
    logic signed [ole_pkg::VALUE_W-1:0] right_v;

    if (gi == 0) begin : g_first
      assign left_v = cell_val[0];
    end else begin : g_mid_l
      assign left_v = cell_val[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_last
      assign right_v = cell_val[0];
    end else begin : g_mid_r
      assign right_v = cell_val[gi+1];
    end

    ole_cell #(
      .IDX_W (IDX_W),
      .IDX   (gi)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .pos        (cell_pos),
      .item_value (in_item_value),
      .left_val   (left_v),
      .right_val  (right_v),
      .val_q      (cell_val[gi])
    );
  end

  // Next state, cell operation and result selection.
  always_comb begin
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] cnt_nxt_ext;
    logic [CMP_W-1:0] sidx_ext;
    logic [CMP_W-1:0] found_ext;
    logic             load_out;

    pos_ext     = CMP_W'(in_position);
    cnt_ext     = CMP_W'(count_r);
    sidx_ext    = CMP_W'(scan_idx_r);
    found_ext   = CMP_W'(found_r);
    load_out    = 1'b0;

    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    is_search_nxt  = is_search_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    hit_nxt        = hit_r;
    rd_nxt         = rd_r;
    found_nxt      = found_r;
    cell_op        = ole_pkg::CELL_HOLD;
    cell_pos       = pos_ext[IDX_W-1:0];
    out_status_nxt = out_status_r;
    out_read_nxt   = out_read_r;
    out_found_nxt  = out_found_r;

    case (state_r)
      ole_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_status_nxt = ole_pkg::STAT_OK;
          out_read_nxt   = '0;
          out_found_nxt  = '0;
          load_out       = 1'b1;
          case (ole_pkg::req_kind_t'(in_tuser))
            ole_pkg::KIND_INSERT: begin
              if (cnt_ext == DEPTH_C) begin
                out_status_nxt = ole_pkg::STAT_FULL;
              end else if (pos_ext > cnt_ext) begin
                out_status_nxt = ole_pkg::STAT_RANGE;
              end else begin
                cell_op   = ole_pkg::CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ole_pkg::KIND_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = ole_pkg::STAT_RANGE;
              end else begin
                cell_op   = ole_pkg::CELL_DELETE;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            ole_pkg::KIND_READ: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = ole_pkg::STAT_RANGE;
                out_read_nxt   = '1;
              end else begin
                load_out      = 1'b0;
                state_nxt     = ole_pkg::ST_SCAN;
                scan_idx_nxt  = '0;
                is_search_nxt = 1'b0;
                pos_nxt       = pos_ext;
                hit_nxt       = 1'b1;
                rd_nxt        = '0;
                found_nxt     = '0;
              end
            end
            ole_pkg::KIND_UPDATE: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = ole_pkg::STAT_RANGE;
              end else begin
                cell_op = ole_pkg::CELL_UPDATE;
              end
            end
            ole_pkg::KIND_SEARCH: begin
              if (count_r == '0) begin
                out_status_nxt = ole_pkg::STAT_NOT_FOUND;
              end else begin
                load_out      = 1'b0;
                state_nxt     = ole_pkg::ST_SCAN;
                scan_idx_nxt  = '0;
                is_search_nxt = 1'b1;
                key_nxt       = in_item_value;
                hit_nxt       = 1'b0;
                rd_nxt        = '0;
                found_nxt     = '0;
              end
            end
            default: begin
              out_status_nxt = ole_pkg::STAT_RANGE;
            end
          endcase
        end
      end

      // One full turn of the row; cell 0 shows entry scan_idx_r this cycle.
      ole_pkg::ST_SCAN: begin
        cell_op = ole_pkg::CELL_ROTATE;
        if (is_search_r) begin
          if (!hit_r && (sidx_ext < cnt_ext) && (cell_val[0] == key_r)) begin
            hit_nxt   = 1'b1;
            found_nxt = scan_idx_r;
          end
        end else if (sidx_ext == pos_r) begin
          rd_nxt = cell_val[0];
        end
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ole_pkg::ST_RESULT;
        end
      end

      // Hand the scan result to the output register once it is free.
      ole_pkg::ST_RESULT: begin
        if (out_free) begin
          load_out       = 1'b1;
          out_status_nxt = hit_r ? ole_pkg::STAT_OK : ole_pkg::STAT_NOT_FOUND;
          out_read_nxt   = rd_r;
          out_found_nxt  = found_ext[ole_pkg::FOUND_W-1:0];
          state_nxt      = ole_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ole_pkg::ST_IDLE;
      end
    endcase

    cnt_nxt_ext   = CMP_W'(count_nxt);
    out_count_nxt = load_out ? cnt_nxt_ext[ole_pkg::COUNT_W-1:0] : out_count_r;
    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !out_tready);
    if (!load_out) begin
      out_status_nxt = out_status_r;
      out_read_nxt   = out_read_r;
      out_found_nxt  = out_found_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ole_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    is_search_r  <= is_search_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    hit_r        <= hit_nxt;
    rd_r         <= rd_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_read_r   <= out_read_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Result channel packing.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_found_r, out_read_r};
  assign out_tuser  = out_status_r;

  // The entry count never exceeds the number of cells.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("entry count above depth");

  // The count moves only on the cycle after a request transfer.
  a_count_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready) |=> $stable(count_r))
    else $error("entry count changed without a request");

  // No request is taken while the row is rotating.
  a_scan_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ole_pkg::ST_SCAN) |-> !in_tready)
    else $error("request taken during scan");

endmodule

`default_nettype wire
